### hdl/nesting_stack_match_pop_unit_defines.svh
// assertion macros for the nesting stack match-pop unit
// used by nsmp_checker; no other dependencies
`ifndef NESTING_STACK_MATCH_POP_UNIT_DEFINES_SVH
`define NESTING_STACK_MATCH_POP_UNIT_DEFINES_SVH

// checked only outside reset
`define NSMP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define NSMP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/nsmp_pkg.sv
// types, codes and sizing for the nesting stack match-pop unit
// no dependencies
`timescale 1ns / 1ps

package nsmp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = IDX_W + 1;
    localparam int DEPTH_OUT_W = 5;
    localparam int DEPTH_EXT_W = (DEPTH_W > DEPTH_OUT_W) ? DEPTH_W : DEPTH_OUT_W;

    localparam logic [1:0] CMD_PUSH      = 2'd0;
    localparam logic [1:0] CMD_POP       = 2'd1;
    localparam logic [1:0] CMD_POP_MATCH = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] entry_handle;
        logic [7:0]  entry_code;
        logic [7:0]  match_code;
    } t_req;

    typedef struct packed {
        logic [1:0]             status;
        logic [15:0]            popped_handle;
        logic [DEPTH_OUT_W-1:0] depth_after;
    } t_rsp;

    typedef struct packed {
        logic [15:0] handle;
        logic [7:0]  code;
    } t_entry;

    // broadcast to every cell
    typedef struct packed {
        logic               en;
        logic [1:0]         cmd;
        logic [DEPTH_W-1:0] depth;
        logic [7:0]         match_code;
        t_entry             new_entry;
    } t_cell_ctl;

    // passed from the newer cell to the older one
    typedef struct packed {
        logic        hit;
        logic [15:0] handle;
    } t_chain;

endpackage

### hdl/nsmp_cell.sv
// one stack slot: holds an entry, flags a hit and shifts down on removal
// depends on nsmp_pkg
`timescale 1ns / 1ps

module nsmp_cell (
    input  logic                      i_clk,
    input  logic [nsmp_pkg::IDX_W-1:0] i_idx,
    input  nsmp_pkg::t_cell_ctl       i_ctl,
    input  logic                      i_found,
    input  nsmp_pkg::t_entry          i_above_entry,
    input  nsmp_pkg::t_chain          i_above,
    output nsmp_pkg::t_entry          o_entry,
    output nsmp_pkg::t_chain          o_below
);
    import nsmp_pkg::*;

    t_entry             r_entry;
    t_entry             n_entry;
    logic [DEPTH_W-1:0] w_idx;
    logic               w_hit;
    logic               w_sel;

    assign w_idx = DEPTH_W'(i_idx);

    always_comb begin
        w_hit = 1'b0;
        if (i_ctl.cmd == CMD_POP) begin
            w_hit = (w_idx + DEPTH_W'(1)) == i_ctl.depth;
        end else if (i_ctl.cmd == CMD_POP_MATCH) begin
            w_hit = (w_idx < i_ctl.depth) && (r_entry.code == i_ctl.match_code);
        end
    end

    assign w_sel          = w_hit && !i_above.hit;
    assign o_below.hit    = i_above.hit || w_hit;
    assign o_below.handle = w_sel ? r_entry.handle : i_above.handle;
    assign o_entry        = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.en) begin
            if (i_ctl.cmd == CMD_PUSH && w_idx == i_ctl.depth) begin
                n_entry = i_ctl.new_entry;
            end else if (i_found && !i_above.hit) begin
                n_entry = i_above_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### hdl/nesting_stack_match_pop_unit.sv
// top level of the nesting stack match-pop unit: depth counter, cell row, response register
// depends on nsmp_pkg and nsmp_cell
//
//   channel   direction  handshake                  payload
//   request   in         i_req_valid / o_req_ready  i_req (t_req)
//   response  out        o_rsp_valid / i_rsp_ready  o_rsp (t_rsp)
//
// one request per cycle unless o_rsp stalls; response valid in the cycle after acceptance
// the cost is one ripple through the cell row (hit flag and popped handle)
// a request is taken while the response register is empty or being drained
// reset clears the depth and the response valid; no clearing pass
`timescale 1ns / 1ps

module nesting_stack_match_pop_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  nsmp_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output nsmp_pkg::t_rsp o_rsp
);
    import nsmp_pkg::*;

    logic [DEPTH_W-1:0]     r_depth;
    logic [DEPTH_W-1:0]     n_depth;
    logic                   r_rsp_valid;
    t_rsp                   r_rsp;
    t_rsp                   n_rsp;
    logic                   w_accept;
    logic                   w_found;
    logic                   w_full;
    logic [DEPTH_EXT_W-1:0] w_depth_ext;
    t_cell_ctl              w_ctl;
    t_entry                 w_cell  [STACK_DEPTH-1:0];
    t_chain                 w_chain [STACK_DEPTH:0];

    assign o_req_ready = !r_rsp_valid || i_rsp_ready;
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_full      = r_depth == DEPTH_W'(STACK_DEPTH);

    assign w_ctl.en                  = w_accept;
    assign w_ctl.cmd                 = i_req.cmd;
    assign w_ctl.depth               = r_depth;
    assign w_ctl.match_code          = i_req.match_code;
    assign w_ctl.new_entry.handle    = i_req.entry_handle;
    assign w_ctl.new_entry.code      = i_req.entry_code;

    assign w_chain[STACK_DEPTH] = '0;

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        t_entry w_above_entry;
        if (i == STACK_DEPTH - 1) begin : g_top
            assign w_above_entry = '0;
        end else begin : g_mid
            assign w_above_entry = w_cell[i+1];
        end
        nsmp_cell u_cell (
            .i_clk         (i_clk),
            .i_idx         (IDX_W'(i)),
            .i_ctl         (w_ctl),
            .i_found       (w_found),
            .i_above_entry (w_above_entry),
            .i_above       (w_chain[i+1]),
            .o_entry       (w_cell[i]),
            .o_below       (w_chain[i])
        );
    end

    assign w_found = w_chain[0].hit;

    always_comb begin
        n_depth = r_depth;
        if (i_req.cmd == CMD_PUSH) begin
            if (!w_full) begin
                n_depth = r_depth + DEPTH_W'(1);
            end
        end else if (w_found) begin
            n_depth = r_depth - DEPTH_W'(1);
        end
    end

    assign w_depth_ext = DEPTH_EXT_W'(n_depth);

    always_comb begin
        n_rsp.popped_handle = w_chain[0].handle;
        n_rsp.depth_after   = w_depth_ext[DEPTH_OUT_W-1:0];
        if (i_req.cmd == CMD_PUSH) begin
            n_rsp.status = w_full ? ST_FULL : ST_OK;
        end else begin
            n_rsp.status = w_found ? ST_OK : ST_NOTFOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_depth <= n_depth;
            end
            if (w_accept) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

### hdl/nsmp_checker.sv
// port-level checks for the nesting stack match-pop unit, bound to the top level
// depends on nsmp_pkg and nesting_stack_match_pop_unit_defines.svh
`timescale 1ns / 1ps
`include "nesting_stack_match_pop_unit_defines.svh"

module nsmp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           o_req_ready,
    input nsmp_pkg::t_req i_req,
    input logic           o_rsp_valid,
    input logic           i_rsp_ready,
    input nsmp_pkg::t_rsp o_rsp
);
    import nsmp_pkg::*;

    logic w_req_fire;
    logic w_req_push;

    assign w_req_fire = i_req_valid && o_req_ready;
    assign w_req_push = i_req.cmd == CMD_PUSH;

    `NSMP_ASSERT_ALWAYS(a_rst_clears_rsp, !i_rst_n |=> !o_rsp_valid, "response valid after reset")

    `NSMP_ASSERT(a_req_gives_rsp, w_req_fire |=> o_rsp_valid, "accepted request without response")

    `NSMP_ASSERT(a_rsp_hold, o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp), "stalled response changed")

    `NSMP_ASSERT(a_fail_no_handle, o_rsp_valid && o_rsp.status != ST_OK |-> o_rsp.popped_handle == '0, "failed request returned a handle")

    `NSMP_ASSERT(a_push_no_handle, w_req_fire && w_req_push |=> o_rsp.popped_handle == '0, "push returned a handle")

endmodule

bind nesting_stack_match_pop_unit nsmp_checker u_nsmp_checker (.*);
